FILE: rtl/core/padlv_pkg.sv
// ----------------------------------------------------------------------------
// padlv_pkg
// Shared types, constants and helpers for the density LRU victim selector.
// ----------------------------------------------------------------------------
package padlv_pkg;

  localparam int TICK_W     = 48;
  localparam int SUBBLOCKS  = 8;
  localparam int WAYS       = 16;
  localparam int NUM_W      = 76;   // (age+1)*total*2^24 is at most 2^75, fits 76 bits
  localparam int DEN_W      = 44;   // valid*(2^24+w*excess*dirty)
  localparam int Q_DEPTH    = 2;

  localparam logic [15:0] THRESH_RST = 16'd52429;
  localparam logic [15:0] WEIGHT_RST = 16'd256;

  typedef enum logic [0:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_WEIGHT    = 1'b1
  } cfg_idx_e_t;

  typedef struct packed {
    logic [3:0]  candidate_index;
    logic [3:0]  valid_subblocks;
    logic [3:0]  total_subblocks;
    logic [3:0]  dirty_subblocks;
    logic        line_dirty;
    logic        sectored;
    logic [47:0] last_touch;
    logic [47:0] now;
    logic [15:0] queue_pressure;
    logic        last_candidate;
  } in_item_t;

  typedef struct packed {
    logic [3:0] victim_index;
    logic       victim_invalid;
  } out_item_t;

  // Classified candidate handed from the front to the back.
  typedef struct packed {
    logic [3:0]       way;
    logic             inval;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [47:0]      touch;
    logic             last;
  } cand_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL0,
    BK_MUL1,
    BK_DECIDE,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DEN,
    FR_PUSH
  } fr_state_t;

  function automatic logic [3:0] sat_cnt(input logic [3:0] v);
    sat_cnt = (v > 4'(SUBBLOCKS)) ? 4'(SUBBLOCKS) : v;
  endfunction

endpackage

FILE: rtl/core/pressure_aware_density_lru_victim_top.sv
// ----------------------------------------------------------------------------
// pressure_aware_density_lru_victim_top
// Pressure-aware density LRU victim selector, one candidate per transaction.
// ----------------------------------------------------------------------------
//  channel | ports                        | direction
//  input   | in_valid/in_ready/in_data    | candidate in
//  result  | out_valid/out_ready/out_data | victim out, on last candidate
//  config  | cfg_valid/cfg_ready/cfg_*    | register writes
//
// The front takes a new transaction only after it has pushed the last one,
// which waits while the queue is full; the back pops a candidate only once
// the last has left BK_DECIDE, or BK_EMIT when it closed its set.
// Reset (rst_n low, synchronous) clears state machines, queue and the
// selection; the registers return to their reset values. Either side may
// stall on its own: the two-entry queue decouples front and back.
// Scores are exact rationals num/den; two scores are compared as
// num_a*den_b against num_b*den_a, built in halves in BK_MUL0 and BK_MUL1.
module pressure_aware_density_lru_victim_top import padlv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] thresh_r, weight_r;
  logic  push, q_full, pop, q_empty;
  cand_t push_data, pop_data;

  assign cfg_ready = 1'b1;

  // Register writes; an index past the list has no effect beyond one bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
      weight_r <= WEIGHT_RST;
    end else if (cfg_valid) begin
      if (cfg_idx_e_t'(cfg_index) == CFG_THRESHOLD) thresh_r <= cfg_data;
      else weight_r <= cfg_data;
    end
  end

  padlv_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .thresh(thresh_r), .weight(weight_r),
    .push, .push_data, .q_full
  );

  padlv_queue u_queue (
    .clk, .rst_n, .push, .push_data, .full(q_full),
    .pop, .empty(q_empty), .pop_data
  );

  padlv_back u_back (
    .clk, .rst_n, .q_empty, .q_data(pop_data), .pop,
    .out_valid, .out_ready, .out_data
  );

`ifndef SYNTHESIS
  // The queue is never written while full nor read while empty.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_empty)) else $error("queue underflow");
  // A waiting result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
`endif

endmodule

FILE: rtl/core/padlv_front.sv
// ----------------------------------------------------------------------------
// padlv_front
// Accepts candidates and forms the exact score as a numerator/denominator.
// ----------------------------------------------------------------------------
module padlv_front import padlv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  logic [15:0] thresh,
  input  logic [15:0] weight,
  output logic        push,
  output cand_t       push_data,
  input  logic        q_full
);

  fr_state_t  st_r, st_nxt;
  in_item_t   it_r;
  logic [31:0] wx_r, wx_nxt;       // weight*excess
  logic [3:0]  dirty_r, dirty_nxt;
  logic [3:0]  valid_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [3:0]  v_s, t_s, d_s;
  logic [48:0] age1;
  logic [35:0] fac;
  logic        pen;

  always_comb begin
    v_s = sat_cnt(in_data.valid_subblocks);
    t_s = sat_cnt((in_data.total_subblocks == 4'd0) ? 4'd1 : in_data.total_subblocks);
    if (in_data.sectored) d_s = sat_cnt(in_data.dirty_subblocks);
    else if (in_data.line_dirty) d_s = (v_s > 4'd0) ? v_s : 4'd1;
    else d_s = 4'd0;
    pen = (in_data.queue_pressure > thresh) && (d_s != 4'd0);
    wx_nxt = pen ? (32'(weight) * 32'(in_data.queue_pressure - thresh)) : 32'd0;
    dirty_nxt = d_s;
    age1 = {1'b0, (in_data.now - in_data.last_touch)} + 49'd1;
  end

  assign fac = 36'd16777216 + 36'(wx_r) * 36'(dirty_r);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      FR_IDLE: if (in_valid) st_nxt = FR_DEN;
      FR_DEN:  st_nxt = FR_PUSH;
      FR_PUSH: if (!q_full) st_nxt = FR_IDLE;
      default: st_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (st_r == FR_IDLE);
    push      = (st_r == FR_PUSH) && !q_full;
    push_data.way   = it_r.candidate_index;
    push_data.inval = (valid_r == 4'd0);
    push_data.num   = (valid_r == 4'd0) ? '0 : num_r;
    push_data.den   = (valid_r == 4'd0) ? '0 : den_r;
    push_data.touch = it_r.last_touch;
    push_data.last  = it_r.last_candidate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= FR_IDLE;
    else st_r <= st_nxt;
    if (st_r == FR_IDLE && in_valid) begin
      it_r    <= in_data;
      wx_r    <= wx_nxt;
      dirty_r <= dirty_nxt;
      valid_r <= v_s;
      num_r   <= NUM_W'({age1, 24'd0}) * NUM_W'(t_s);
    end
    if (st_r == FR_DEN) den_r <= DEN_W'(fac) * DEN_W'(valid_r);
  end

endmodule

FILE: rtl/core/padlv_queue.sv
// ----------------------------------------------------------------------------
// padlv_queue
// Small FIFO of classified candidates between front and back.
// ----------------------------------------------------------------------------
module padlv_queue import padlv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  cand_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output cand_t pop_data
);

  cand_t      mem_r [Q_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'(Q_DEPTH));
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

FILE: rtl/core/padlv_back.sv
// ----------------------------------------------------------------------------
// padlv_back
// Compares each candidate with the best so far: invalid first, then score.
// ----------------------------------------------------------------------------
module padlv_back import padlv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cand_t     q_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  bk_state_t st_r, st_nxt;
  cand_t     c_r;
  logic      have_r;
  logic [3:0]  bway_r;
  logic        binv_r;
  logic [NUM_W-1:0] bnum_r;
  logic [DEN_W-1:0] bden_r;
  logic [47:0] btouch_r;
  logic [NUM_W+DEN_W-1:0] lhs_r, rhs_r;
  out_item_t res_r;
  logic take;

  // Each cross product is built in two halves of the denominator.
  localparam int HD = DEN_W / 2;

  always_comb begin
    if (!have_r) take = 1'b1;
    else if (c_r.inval != binv_r) take = c_r.inval;
    else if (c_r.inval) take = (c_r.touch < btouch_r);
    else take = (lhs_r > rhs_r) || ((lhs_r == rhs_r) && (c_r.touch < btouch_r));
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:   if (!q_empty) st_nxt = BK_MUL0;
      BK_MUL0:   st_nxt = BK_MUL1;
      BK_MUL1:   st_nxt = BK_DECIDE;
      BK_DECIDE: st_nxt = c_r.last ? BK_EMIT : BK_IDLE;
      BK_EMIT:   if (out_ready) st_nxt = BK_IDLE;
      default:   st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = (st_r == BK_IDLE) && !q_empty;
    out_valid = (st_r == BK_EMIT);
    out_data  = res_r;
  end

  // Every numerator carries a factor of 2^24 in its low zero bits; it is
  // common to both sides, so only the upper bits enter the products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      have_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_DECIDE) have_r <= c_r.last ? 1'b0 : (have_r | take);
    end
    case (st_r)
      BK_IDLE: c_r <= q_data;
      BK_MUL0: begin
        lhs_r <= (NUM_W+DEN_W)'(c_r.num[NUM_W-1:24]) * (NUM_W+DEN_W)'(bden_r[HD-1:0]);
        rhs_r <= (NUM_W+DEN_W)'(bnum_r[NUM_W-1:24])  * (NUM_W+DEN_W)'(c_r.den[HD-1:0]);
      end
      BK_MUL1: begin
        lhs_r <= lhs_r + ((NUM_W+DEN_W)'(c_r.num[NUM_W-1:24])
                 * (NUM_W+DEN_W)'(bden_r[DEN_W-1:HD]) << HD);
        rhs_r <= rhs_r + ((NUM_W+DEN_W)'(bnum_r[NUM_W-1:24])
                 * (NUM_W+DEN_W)'(c_r.den[DEN_W-1:HD]) << HD);
      end
      BK_DECIDE: begin
        if (take) begin
          res_r <= '{victim_index: c_r.way, victim_invalid: c_r.inval};
        end else begin
          res_r <= '{victim_index: bway_r, victim_invalid: binv_r};
        end
        if (c_r.last) begin
          bway_r <= '0; binv_r <= 1'b0; bnum_r <= '0; bden_r <= '0; btouch_r <= '0;
        end else if (take) begin
          bway_r <= c_r.way; binv_r <= c_r.inval; bnum_r <= c_r.num;
          bden_r <= c_r.den; btouch_r <= c_r.touch;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sim/tb_pressure_aware_density_lru_victim_top.sv
// ----------------------------------------------------------------------------
// tb_pressure_aware_density_lru_victim_top
// Self-checking bench for the victim selector: a directed table of candidate
// sets, then random sets in four phases (two with idling) and a long output stall,
// every victim checked against a local exact-rational scoring model.
// ----------------------------------------------------------------------------
module tb_pressure_aware_density_lru_victim_top;
  import padlv_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1450;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_THRESHOLD;
  logic [15:0] cfg_data = '0;

  always #HALF_PERIOD clk = ~clk;

  pressure_aware_density_lru_victim_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Local copy of the registers and of the running best-so-far selection.
  logic [15:0]  thresh_q;
  logic [15:0]  weight_q;
  logic         sel_have;
  logic [3:0]   sel_way;
  logic         sel_inval;
  logic [127:0] sel_num;
  logic [127:0] sel_den;
  logic [47:0]  sel_touch;

  out_item_t victim_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off;
  int unsigned hold_cycles;
  int unsigned cycle_cnt;
  int unsigned mismatches;
  int unsigned victims_seen;
  int unsigned sets_sent;
  int unsigned items_sent;

  function automatic logic [3:0] clamp_count(input logic [3:0] v);
    return (v > 4'd8) ? 4'd8 : v;
  endfunction

  // Scores one candidate and folds it into the running selection; returns 1
  // and fills the victim when the candidate closes its set.
  function automatic bit score_candidate(input in_item_t c, output out_item_t v);
    logic [3:0]   nvalid, ntotal, ndirty;
    logic [127:0] num, den, factor, lhs, rhs;
    logic [48:0]  age_p1;
    logic         inval;
    bit           take;
    nvalid = clamp_count(c.valid_subblocks);
    ntotal = (c.total_subblocks == 4'd0) ? 4'd1 : clamp_count(c.total_subblocks);
    if (c.sectored) ndirty = clamp_count(c.dirty_subblocks);
    else if (c.line_dirty) ndirty = (nvalid > 0) ? nvalid : 4'd1;
    else ndirty = 4'd0;
    inval = (nvalid == 4'd0);
    num = '0;
    den = '0;
    if (!inval) begin
      age_p1 = {1'b0, c.now - c.last_touch} + 49'd1;
      num = 128'(age_p1) * 128'(ntotal) << 24;
      factor = 128'(1) << 24;
      if (c.queue_pressure > thresh_q && ndirty != 0)
        factor += 128'(weight_q) * 128'(c.queue_pressure - thresh_q) * 128'(ndirty);
      den = 128'(nvalid) * factor;
    end
    take = 1'b0;
    if (!sel_have) take = 1'b1;
    else if (inval != sel_inval) take = inval;
    else begin
      // Cross products stay below 2^128: num < 2^77, den < 2^45.
      lhs = inval ? '0 : num * sel_den;
      rhs = inval ? '0 : sel_num * den;
      if (lhs > rhs) take = 1'b1;
      else if (lhs == rhs && c.last_touch < sel_touch) take = 1'b1;
    end
    if (take) begin
      sel_have = 1'b1;
      sel_way = c.candidate_index;
      sel_inval = inval;
      sel_num = num;
      sel_den = den;
      sel_touch = c.last_touch;
    end
    v = '{victim_index: sel_way, victim_invalid: sel_inval};
    if (!c.last_candidate) return 1'b0;
    sel_have = 1'b0;
    sel_way = '0;
    sel_inval = 1'b0;
    sel_num = '0;
    sel_den = '0;
    sel_touch = '0;
    return 1'b1;
  endfunction

  // Offers one candidate, waits for its acceptance and queues any victim.
  // Valid drops only while the sender idles, so back-to-back offers keep it high.
  task automatic send_candidate(input in_item_t c, input bit pinned, input out_item_t pin_v);
    out_item_t v;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (score_candidate(c, v)) begin
      // A typed-in expectation must agree with the scoring model as well.
      if (pinned && v != pin_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row disagrees with model: row %p model %p", pin_v, v);
      end
      victim_q.push_back(pinned ? pin_v : v);
      sets_sent++;
    end
  endtask

  task automatic write_reg(input cfg_idx_e_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_THRESHOLD) thresh_q = value;
    else weight_q = value;
  endtask

  // Waits for all victims, then lets the pipeline empty before a reg write.
  task automatic drain;
    in_valid <= 1'b0;
    while (victim_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t random_candidate(input bit last);
    in_item_t c;
    int unsigned pick;
    c.candidate_index = 4'($urandom_range(15));
    pick = $urandom_range(99);
    // Counts mostly legal, now and then above the saturation point.
    c.valid_subblocks = 4'(pick < 10 ? $urandom_range(15) :
                           pick < 25 ? 0 : $urandom_range(8));
    c.total_subblocks = 4'($urandom_range(99) < 10 ? $urandom_range(15) : $urandom_range(8));
    c.dirty_subblocks = 4'($urandom_range(99) < 10 ? $urandom_range(15) : $urandom_range(8));
    c.line_dirty = 1'($urandom_range(1));
    c.sectored = 1'($urandom_range(1));
    c.now = 48'({$urandom(), $urandom()});
    // Small ages make ties and close scores likely; some wrap around.
    case ($urandom_range(3))
      0: c.last_touch = c.now - 48'($urandom_range(3));
      1: c.last_touch = c.now - 48'($urandom_range(40));
      2: c.last_touch = c.now + 48'($urandom_range(40));
      default: c.last_touch = 48'({$urandom(), $urandom()});
    endcase
    c.queue_pressure = 16'($urandom_range(99) < 50 ? $urandom : thresh_q + $urandom_range(3));
    c.last_candidate = last;
    return c;
  endfunction

  task automatic random_sets(input int unsigned n_items);
    int unsigned left, set_len, k;
    left = n_items;
    while (left != 0) begin
      set_len = $urandom_range(99) < 10 ? 1 : $urandom_range(16, 2);
      if (set_len > left) set_len = left;
      for (k = 0; k < set_len; k++)
        send_candidate(random_candidate(k == set_len - 1), 1'b0, '0);
      left -= set_len;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long hold-off counted here; the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_off <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      hold_off <= 1'b0;
    end
  end

  // Victim checker: compares every accepted result with the oldest expected.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      victims_seen++;
      if (victim_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected victim %p", out_data);
      end else begin
        want = victim_q.pop_front();
        if (out_data.victim_index != want.victim_index ||
            out_data.victim_invalid != want.victim_invalid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("victim mismatch: expected way %0d inval %0d, got way %0d inval %0d",
                     want.victim_index, want.victim_invalid,
                     out_data.victim_index, out_data.victim_invalid);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Directed table: one candidate per row. Rows carrying a typed-in victim
  // close their set; other rows build a set up or close one the model predicts.
  typedef struct {
    in_item_t  cand;
    bit        pinned;
    out_item_t victim;
  } dir_row_t;

  function automatic in_item_t mk(input logic [3:0] way, input logic [3:0] vld,
                                  input logic [3:0] tot, input logic [3:0] drt,
                                  input logic ld, input logic sec,
                                  input logic [47:0] touch, input logic [47:0] tnow,
                                  input logic [15:0] pr, input logic last);
    return '{way, vld, tot, drt, ld, sec, touch, tnow, pr, last};
  endfunction

  initial begin
    dir_row_t rows[$];
    int i;
    thresh_q = THRESH_RST;
    weight_q = WEIGHT_RST;
    sel_have = 0; sel_way = '0; sel_inval = 0;
    sel_num = '0; sel_den = '0; sel_touch = '0;
    send_idle_pct = 14;
    recv_idle_pct = 45;
    hold_off = 0; hold_cycles = 0;
    cycle_cnt = 0; mismatches = 0; victims_seen = 0;
    sets_sent = 0; items_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single candidate right after reset: it always wins.
    rows.push_back('{mk(4'd15, 4'd8, 4'd8, 4'd8, 1, 1, '1, '1, '1, 1), 1, '{4'd15, 1'b0}});
    // Invalid line beats any valid one.
    rows.push_back('{mk(4'd1, 4'd8, 4'd8, 4'd0, 0, 0, 48'd0, '1, 16'd0, 0), 0, '0});
    rows.push_back('{mk(4'd2, 4'd0, 4'd0, 4'd0, 0, 0, '1, '1, 16'd0, 1), 1, '{4'd2, 1'b1}});
    // Two invalid lines: the smaller touch tick wins.
    rows.push_back('{mk(4'd3, 4'd0, 4'd1, 4'd0, 1, 0, 48'd9, 48'd9, '1, 0), 0, '0});
    rows.push_back('{mk(4'd4, 4'd0, 4'd1, 4'd0, 1, 0, 48'd5, 48'd9, '1, 1), 1, '{4'd4, 1'b1}});
    // Tick wrap, maximum age, and a fully equal pair where the first stays.
    rows.push_back('{mk(4'd5, 4'd1, 4'd8, 4'd0, 0, 0, 48'd1, 48'd0, 16'd0, 0), 0, '0});
    rows.push_back('{mk(4'd6, 4'd1, 4'd8, 4'd0, 0, 0, 48'd1, 48'd0, 16'd0, 1), 1, '{4'd5, 1'b0}});
    // Plain dirty line at full pressure is penalized; saturated counts.
    rows.push_back('{mk(4'd7, 4'd15, 4'd15, 4'd15, 1, 0, 48'd0, 48'd100, '1, 0), 0, '0});
    rows.push_back('{mk(4'd8, 4'd8, 4'd8, 4'd15, 0, 1, 48'd0, 48'd100, '1, 0), 0, '0});
    rows.push_back('{mk(4'd9, 4'd4, 4'd0, 4'd8, 0, 1, 48'd0, 48'd100, '1, 1), 0, '0});
    // Pressure just at and just above the threshold.
    rows.push_back('{mk(4'd10, 4'd2, 4'd4, 4'd2, 0, 1, 48'd10, 48'd20, THRESH_RST, 0), 0, '0});
    rows.push_back('{mk(4'd11, 4'd2, 4'd4, 4'd2, 0, 1, 48'd10, 48'd20,
                        THRESH_RST + 16'd1, 0), 0, '0});
    rows.push_back('{mk(4'd12, 4'd2, 4'd4, 4'd0, 1, 0, 48'd10, 48'd20, '1, 1), 0, '0});
    for (i = 0; i < rows.size(); i++)
      send_candidate(rows[i].cand, rows[i].pinned, rows[i].victim);
    drain();

    // Extreme register settings, the directed rows again, then random sets.
    write_reg(CFG_THRESHOLD, 16'd0);
    write_reg(CFG_WEIGHT, 16'hFFFF);
    for (i = 0; i < rows.size(); i++)
      send_candidate(rows[i].cand, 1'b0, '0);
    random_sets(RANDOM_ITEMS / 4);
    drain();

    send_idle_pct = 45;
    recv_idle_pct = 14;
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    write_reg(CFG_WEIGHT, 16'd0);
    random_sets(RANDOM_ITEMS / 4);
    drain();

    // No idling, random settings, and one long stall of the receiver.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_THRESHOLD, 16'($urandom));
    write_reg(CFG_WEIGHT, 16'($urandom));
    hold_cycles = 300;
    random_sets(RANDOM_ITEMS / 4);
    drain();

    write_reg(CFG_THRESHOLD, THRESH_RST);
    write_reg(CFG_WEIGHT, WEIGHT_RST);
    random_sets(RANDOM_ITEMS / 4);
    drain();

    $display("Covered %0d candidates in %0d sets, %0d victims checked.",
             items_sent, sets_sent, victims_seen);
    $display("Register settings went from zero to full scale across four phases.");
    if (mismatches == 0 && victim_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/padlv_pkg.sv
rtl/core/padlv_front.sv
rtl/core/padlv_queue.sv
rtl/core/padlv_back.sv
rtl/core/pressure_aware_density_lru_victim_top.sv
sim/tb_pressure_aware_density_lru_victim_top.sv
